FILE: hdl/u8dc_pkg.sv
// u8dc_pkg: shared types and constants for the UTF-8 decode and classify block.
// Used by the decoder, the classifier and the top level. No dependencies.

package u8dc_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CpW    = 21;
   localparam int unsigned ClassW = 2;

   // Lead byte boundaries and payload masks
   localparam logic [ByteW-1:0] LeadTwo   = 8'h80;
   localparam logic [ByteW-1:0] LeadThree = 8'hE0;
   localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
   localparam logic [ByteW-1:0] MaskTwo   = 8'h1F;
   localparam logic [ByteW-1:0] MaskThree = 8'h0F;
   localparam logic [ByteW-1:0] MaskFour  = 8'h07;
   localparam logic [ByteW-1:0] MaskCont  = 8'h3F;

   // CJK ranges, inclusive
   localparam logic [CpW-1:0] CjkUnifLo = 21'h004E00;
   localparam logic [CpW-1:0] CjkUnifHi = 21'h009FFF;
   localparam logic [CpW-1:0] CjkExtALo = 21'h003400;
   localparam logic [CpW-1:0] CjkExtAHi = 21'h004DBF;
   localparam logic [CpW-1:0] KanaLo    = 21'h003040;
   localparam logic [CpW-1:0] KanaHi    = 21'h0030FF;
   localparam logic [CpW-1:0] HangulLo  = 21'h00AC00;
   localparam logic [CpW-1:0] HangulHi  = 21'h00D7AF;
   localparam logic [CpW-1:0] JamoLo    = 21'h003131;
   localparam logic [CpW-1:0] JamoHi    = 21'h003163;

   typedef enum logic [1:0] {
      BYTES_NONE  = 2'd0,
      BYTES_ONE   = 2'd1,
      BYTES_TWO   = 2'd2,
      BYTES_THREE = 2'd3
   } bytes_left_type;

   typedef enum logic [ClassW-1:0] {
      CLASS_SEP  = 2'd0,
      CLASS_WORD = 2'd1,
      CLASS_CJK  = 2'd2
   } char_class_type;

   // One byte as held in the input stage
   typedef struct packed {
      logic [ByteW-1:0] byte_in;
      logic             last_byte;
   } in_item_type;

   // Decoder result toward the output register
   typedef struct packed {
      logic           valid;
      logic [CpW-1:0] code_point;
      logic           ends_text;
      logic           truncated;
   } dec_result_type;

endpackage

FILE: hdl/u8dc_req_if.sv
// u8dc_req_if: byte channel (valid/ready) into the decoder.
// Depends on u8dc_pkg for widths.

interface u8dc_req_if
   import u8dc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] byte_in;
   logic             last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

FILE: hdl/u8dc_rsp_if.sv
// u8dc_rsp_if: code point channel (valid/ready) out of the decoder.
// Depends on u8dc_pkg for widths.

interface u8dc_rsp_if
   import u8dc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CpW-1:0]    code_point;
   logic [ClassW-1:0] char_class;
   logic              ends_text;
   logic              truncated;

   modport source (output valid, output code_point, output char_class,
                   output ends_text, output truncated, input ready);
   modport sink   (input valid, input code_point, input char_class,
                   input ends_text, input truncated, output ready);
endinterface

FILE: hdl/u8dc_classifier.sv
// u8dc_classifier: range compares that sort a code point into CJK, word or separator.
// Depends on u8dc_pkg.

module u8dc_classifier
   import u8dc_pkg::*;
(
   input  logic [CpW-1:0] code_point,
   output char_class_type char_class
);

   logic       is_cjk;
   logic       is_ascii_word;
   logic [6:0] low7;

   assign low7 = code_point[6:0];

   assign is_cjk = (code_point >= CjkUnifLo && code_point <= CjkUnifHi) ||
                   (code_point >= CjkExtALo && code_point <= CjkExtAHi) ||
                   (code_point >= KanaLo    && code_point <= KanaHi)    ||
                   (code_point >= HangulLo  && code_point <= HangulHi)  ||
                   (code_point >= JamoLo    && code_point <= JamoHi);

   // only meaningful below 0x80
   assign is_ascii_word = (low7 >= 7'h61 && low7 <= 7'h7A) ||
                          (low7 >= 7'h41 && low7 <= 7'h5A) ||
                          (low7 >= 7'h30 && low7 <= 7'h39) ||
                          low7 == 7'h5F || low7 == 7'h2D || low7 == 7'h2E;

   always_comb begin
      if (is_cjk) begin
         char_class = CLASS_CJK;
      end else if (code_point[CpW-1:7] != '0) begin
         char_class = CLASS_WORD;
      end else if (is_ascii_word) begin
         char_class = CLASS_WORD;
      end else begin
         char_class = CLASS_SEP;
      end
   end

endmodule

FILE: hdl/u8dc_decoder.sv
// u8dc_decoder: sequence state (partial value, bytes left) and one decode step per byte.
// Depends on u8dc_pkg.

module u8dc_decoder
   import u8dc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,      // item in the input stage is consumed this cycle
   input  in_item_type    item,
   output dec_result_type result
);

   logic [CpW-1:0] partial_ff, partial_in;
   bytes_left_type bytes_left_ff, bytes_left_in;

   logic [ByteW-1:0] b;
   logic             done;
   logic [CpW-1:0]   cp;
   logic [CpW-1:0]   shifted;

   assign b       = item.byte_in;
   assign shifted = {partial_ff[CpW-7:0], b[5:0]};

   always_comb begin
      partial_in    = partial_ff;
      bytes_left_in = bytes_left_ff;
      done          = 1'b0;
      cp            = '0;

      if (bytes_left_ff != BYTES_NONE) begin
         partial_in    = shifted;
         bytes_left_in = bytes_left_type'(bytes_left_ff - 2'd1);
         if (bytes_left_ff == BYTES_ONE) begin
            cp   = shifted;
            done = 1'b1;
         end
      end else if (b < LeadTwo) begin
         cp   = CpW'(b);
         done = 1'b1;
      end else if (b < LeadThree) begin
         partial_in    = CpW'(b & MaskTwo);
         bytes_left_in = BYTES_ONE;
      end else if (b < LeadFour) begin
         partial_in    = CpW'(b & MaskThree);
         bytes_left_in = BYTES_TWO;
      end else begin
         partial_in    = CpW'(b & MaskFour);
         bytes_left_in = BYTES_THREE;
      end

      if (done) begin
         partial_in = '0;
      end else if (item.last_byte) begin
         // text ended mid-sequence: drop it
         partial_in    = '0;
         bytes_left_in = BYTES_NONE;
      end

      result.valid      = done || item.last_byte;
      result.code_point = done ? cp : '0;
      result.ends_text  = item.last_byte;
      result.truncated  = !done && item.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         bytes_left_ff <= BYTES_NONE;
      end else if (step) begin
         partial_ff    <= partial_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> bytes_left_ff == BYTES_NONE && partial_ff == '0)
      else $error("decoder state not clear after last byte");
`endif

endmodule

FILE: hdl/utf8_decode_and_classify_top.sv
// Lenient UTF-8 decoder with character classing. Bytes enter on req_ch one per
// transaction, last_byte flagging the end of a text; each completed code point
// leaves on rsp_ch with its class (separator, word, CJK) and an ends_text flag.
// A text that ends inside a multi-byte sequence yields one transaction with
// truncated set and code point 0. Continuation bytes are not checked.
// Throughput is one byte per cycle while rsp_ch is not stalled: every byte passes
// an input register, one decode-and-classify step, and the result register. A
// result is loaded into the result register when its byte steps out of the input
// register; a stalled rsp_ch holds the byte in the input register until the
// result register frees up. Bytes inside an unfinished sequence produce no
// result. No configuration and no memories.
// Depends on u8dc_pkg, u8dc_req_if, u8dc_rsp_if, u8dc_decoder, u8dc_classifier.

module utf8_decode_and_classify_top
   import u8dc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   u8dc_req_if.sink   req_ch,
   u8dc_rsp_if.source rsp_ch
);

   // Input stage
   logic        in_valid_ff, in_valid_in;
   in_item_type in_item_ff;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic [CpW-1:0]    out_cp_ff;
   char_class_type    out_class_ff;
   logic              out_ends_ff;
   logic              out_trunc_ff;

   logic           out_free;   // result register may load this cycle
   logic           step;       // input stage item processed this cycle
   logic           req_take;
   dec_result_type dec_result;
   char_class_type dec_class;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign step     = in_valid_ff && out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   // input stage refills in the same cycle it drains
   assign req_ch.ready = !in_valid_ff || out_free;
   assign in_valid_in  = req_take || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.byte_in   <= req_ch.byte_in;
         in_item_ff.last_byte <= req_ch.last_byte;
      end
   end

   u8dc_decoder u_decoder (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (dec_result)
   );

   u8dc_classifier u_classifier (
      .code_point (dec_result.code_point),
      .char_class (dec_class)
   );

   // Result register: loads on a processed byte, clears when drained with nothing new
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = step && dec_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && dec_result.valid) begin
         out_cp_ff    <= dec_result.code_point;
         // truncated results always report separator
         out_class_ff <= dec_result.truncated ? CLASS_SEP : dec_class;
         out_ends_ff  <= dec_result.ends_text;
         out_trunc_ff <= dec_result.truncated;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.code_point = out_cp_ff;
   assign rsp_ch.char_class = out_class_ff;
   assign rsp_ch.ends_text  = out_ends_ff;
   assign rsp_ch.truncated  = out_trunc_ff;

`ifndef SYNTHESIS
   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_trunc_ff |->
         out_cp_ff == '0 && out_ends_ff && out_class_ff == CLASS_SEP)
      else $error("truncated result malformed");

   a_cjk_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_class_ff == CLASS_CJK |->
         out_cp_ff >= KanaLo && out_cp_ff <= HangulHi)
      else $error("CJK class outside CJK span");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff)
      else $error("result lost while stalled");
`endif

endmodule
